### hw/rtl/adaptive_morse_key_classifier_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Morse key classifier
// Wraps concurrent assertions so that they drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_MORSE_KEY_CLASSIFIER_CORE_DEFINES_SVH
`define ADAPTIVE_MORSE_KEY_CLASSIFIER_CORE_DEFINES_SVH

`ifndef SYNTH
`define AMKC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AMKC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AMKC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define AMKC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/amkc_pkg.sv
// ----------------------------------------------------------------------------
// Morse key classifier package
// Shared widths, codes, reset values and the configuration structure.
// ----------------------------------------------------------------------------
package amkc_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int AVG_WIDTH_DEF  = 16;

    localparam int NOW_W     = 32;
    localparam int FIELD_W   = 16;
    localparam int SYM_W     = 3;
    localparam int PH_W      = 3;
    localparam int REG_IDX_W = 2;

    localparam logic [PH_W-1:0] PH_IDLE = 3'd0;
    localparam logic [PH_W-1:0] PH_DOWN = 3'd1;
    localparam logic [PH_W-1:0] PH_UP   = 3'd2;
    localparam logic [PH_W-1:0] PH_EOC  = 3'd3;
    localparam logic [PH_W-1:0] PH_EOW  = 3'd4;

    localparam logic [SYM_W-1:0] SYM_NONE = 3'd0;
    localparam logic [SYM_W-1:0] SYM_DIT  = 3'd1;
    localparam logic [SYM_W-1:0] SYM_DAH  = 3'd2;
    localparam logic [SYM_W-1:0] SYM_EOC  = 3'd3;
    localparam logic [SYM_W-1:0] SYM_EOW  = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_MIN_DIT      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_DAH      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_IDLE_TIMEOUT = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_ADAPT_EN     = 2'd3;

    localparam logic [FIELD_W-1:0] MIN_DIT_RESET      = 16'd20;
    localparam logic [FIELD_W-1:0] MAX_DAH_RESET      = 16'd500;
    localparam logic [FIELD_W-1:0] IDLE_TIMEOUT_RESET = 16'd5000;
    localparam logic               ADAPT_EN_RESET     = 1'b1;

    localparam int DIT_RESET = 50;
    localparam int DAH_RESET = 200;
    localparam int THR_RESET = 100;

    typedef struct packed {
        logic [FIELD_W-1:0] min_dit;
        logic [FIELD_W-1:0] max_dah;
        logic [FIELD_W-1:0] idle_timeout;
        logic               adapt_en;
    } cfg_t;

endpackage

### hw/rtl/amkc_if.sv
// ----------------------------------------------------------------------------
// Morse key classifier channels
// Valid/ready channels for key samples and classification results.
// ----------------------------------------------------------------------------
interface amkc_sample_if;
    logic                       valid;
    logic                       ready;
    logic                       key_pressed;
    logic [amkc_pkg::NOW_W-1:0] now_ms;

    modport source (output valid, output key_pressed, output now_ms, input ready);
    modport sink   (input valid, input key_pressed, input now_ms, output ready);
endinterface

interface amkc_result_if;
    logic                         valid;
    logic                         ready;
    logic [amkc_pkg::SYM_W-1:0]   symbol;
    logic [amkc_pkg::FIELD_W-1:0] dit_average;
    logic [amkc_pkg::FIELD_W-1:0] dah_average;
    logic [amkc_pkg::FIELD_W-1:0] split_threshold;

    modport source (output valid, output symbol, output dit_average,
                    output dah_average, output split_threshold, input ready);
    modport sink   (input valid, input symbol, input dit_average,
                    input dah_average, input split_threshold, output ready);
endinterface

### hw/rtl/amkc_cfg.sv
// ----------------------------------------------------------------------------
// Morse key classifier configuration registers
// Write-only register file for the timing limits and the adaptation switch.
// ----------------------------------------------------------------------------
module amkc_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [amkc_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [amkc_pkg::FIELD_W-1:0]      wr_data,
    output amkc_pkg::cfg_t                    cfg
);
    import amkc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_MIN_DIT:      cfg_next.min_dit      = wr_data;
                REG_MAX_DAH:      cfg_next.max_dah      = wr_data;
                REG_IDLE_TIMEOUT: cfg_next.idle_timeout = wr_data;
                REG_ADAPT_EN:     cfg_next.adapt_en     = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_dit      <= MIN_DIT_RESET;
            cfg_reg.max_dah      <= MAX_DAH_RESET;
            cfg_reg.idle_timeout <= IDLE_TIMEOUT_RESET;
            cfg_reg.adapt_en     <= ADAPT_EN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/amkc_engine.sv
// ----------------------------------------------------------------------------
// Morse key classifier engine
// Holds the key phase, timestamps and running averages, and works out the
// symbol and the updated averages for one sample combinationally.
// ----------------------------------------------------------------------------
`include "adaptive_morse_key_classifier_core_defines.svh"

module amkc_engine #(
    parameter int TIME_WIDTH = amkc_pkg::TIME_WIDTH_DEF,
    parameter int AVG_WIDTH  = amkc_pkg::AVG_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         key,
    input  logic [amkc_pkg::NOW_W-1:0]   now,
    input  amkc_pkg::cfg_t               cfg,
    output logic [amkc_pkg::SYM_W-1:0]   sym,
    output logic [AVG_WIDTH-1:0]         dit_avg,
    output logic [AVG_WIDTH-1:0]         dah_avg,
    output logic [AVG_WIDTH-1:0]         thr_avg
);
    import amkc_pkg::*;

    localparam int CW = (TIME_WIDTH > AVG_WIDTH + 4) ? TIME_WIDTH : AVG_WIDTH + 4;
    localparam int QW = AVG_WIDTH + 5;
    localparam int XW = AVG_WIDTH + FIELD_W;
    localparam int PW = 2 * QW + 1;
    localparam int D10_S = QW + 4;
    localparam longint unsigned D10_ML = ((64'd1 << D10_S) / 64'd10) + 64'd1;
    localparam logic [QW:0] D10_M = (QW + 1)'(D10_ML);
    localparam logic [AVG_WIDTH-1:0] AVG_MAX = '1;

    logic [PH_W-1:0]       phase_reg,   phase_next;
    logic [TIME_WIDTH-1:0] press_reg,   press_next;
    logic [TIME_WIDTH-1:0] release_reg, release_next;
    logic [AVG_WIDTH-1:0]  dit_reg,     dit_next;
    logic [AVG_WIDTH-1:0]  dah_reg,     dah_next;
    logic [AVG_WIDTH-1:0]  thr_reg,     thr_next;

    logic [TIME_WIDTH-1:0]  now_t;
    logic [CW-1:0]          dur_w;
    logic [CW-1:0]          pause_w;
    logic [CW+1:0]          bounce_lim;
    logic                   bounce;
    logic                   long_press;
    logic [AVG_WIDTH-1:0]   cap;
    logic [AVG_WIDTH-1:0]   floor_eff;
    logic [AVG_WIDTH+3:0]   cap_lim;
    logic                   dah_sat;
    logic [QW-1:0]          div_in;
    logic [PW-1:0]          div_prod;
    logic [AVG_WIDTH+1:0]   quot;
    logic [AVG_WIDTH-1:0]   dah_upd;
    logic [AVG_WIDTH-1:0]   dit_upd;
    logic [AVG_WIDTH+1:0]   dah_x3;
    logic [AVG_WIDTH+1:0]   thr_sum;

    assign now_t   = TIME_WIDTH'(now);
    assign dur_w   = CW'(now_t - press_reg);
    assign pause_w = CW'(now_t - release_reg);

    // A press of at most a third of the dit average, less one, is contact bounce.
    assign bounce_lim = (CW + 2)'(dur_w) * (CW + 2)'(3) + (CW + 2)'(3);
    assign bounce     = bounce_lim <= (CW + 2)'(dit_reg);
    assign long_press = dur_w > CW'(thr_reg);

    always_comb
    begin
        if (XW'(cfg.max_dah) > XW'(AVG_MAX))
        begin
            cap = AVG_MAX;
        end
        else
        begin
            cap = AVG_WIDTH'(cfg.max_dah);
        end
        if (XW'(cfg.min_dit) > XW'(AVG_MAX))
        begin
            floor_eff = AVG_MAX;
        end
        else
        begin
            floor_eff = AVG_WIDTH'(cfg.min_dit);
        end
    end

    // Any press of at least ten times one more than the ceiling saturates the dah average.
    assign cap_lim = (AVG_WIDTH + 4)'(cap) * (AVG_WIDTH + 4)'(10) + (AVG_WIDTH + 4)'(10);
    assign dah_sat = dur_w >= CW'(cap_lim);

    // Shared nine-to-one average, divided by ten through a reciprocal.
    assign div_in   = QW'(long_press ? dah_reg : dit_reg) * QW'(9) + QW'(dur_w[AVG_WIDTH+3:0]);
    assign div_prod = PW'(div_in) * PW'(D10_M);
    assign quot     = div_prod[D10_S +: AVG_WIDTH + 2];

    always_comb
    begin
        if (dah_sat || quot > (AVG_WIDTH + 2)'(cap))
        begin
            dah_upd = cap;
        end
        else
        begin
            dah_upd = quot[AVG_WIDTH-1:0];
        end
        if (quot[AVG_WIDTH-1:0] < floor_eff)
        begin
            dit_upd = floor_eff;
        end
        else
        begin
            dit_upd = quot[AVG_WIDTH-1:0];
        end
    end

    assign dah_x3  = (AVG_WIDTH + 2)'(dah_reg) * (AVG_WIDTH + 2)'(3);
    assign thr_sum = (AVG_WIDTH + 2)'(dit_reg) * (AVG_WIDTH + 2)'(3) + (AVG_WIDTH + 2)'(dah_reg);

    always_comb
    begin
        phase_next   = phase_reg;
        press_next   = press_reg;
        release_next = release_reg;
        dit_next     = dit_reg;
        dah_next     = dah_reg;
        thr_next     = thr_reg;
        sym          = SYM_NONE;
        if (step)
        begin
            if (key)
            begin
                if (phase_reg != PH_DOWN)
                begin
                    press_next = now_t;
                    phase_next = PH_DOWN;
                end
            end
            else if (phase_reg == PH_DOWN)
            begin
                release_next = now_t;
                phase_next   = PH_UP;
                if (!bounce)
                begin
                    if (long_press)
                    begin
                        dah_next = dah_upd;
                        sym      = SYM_DAH;
                    end
                    else
                    begin
                        dit_next = dit_upd;
                        sym      = SYM_DIT;
                    end
                end
            end
            else if (phase_reg == PH_UP && pause_w > CW'(dah_reg))
            begin
                phase_next = PH_EOC;
                sym        = SYM_EOC;
            end
            else if (phase_reg == PH_EOC && pause_w > CW'(dah_x3))
            begin
                phase_next = PH_EOW;
                sym        = SYM_EOW;
                if (cfg.adapt_en)
                begin
                    thr_next = thr_sum[AVG_WIDTH+1:2];
                end
            end
            else if (phase_reg == PH_EOW && pause_w > CW'(cfg.idle_timeout))
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            press_reg   <= '0;
            release_reg <= '0;
            dit_reg     <= AVG_WIDTH'(DIT_RESET);
            dah_reg     <= AVG_WIDTH'(DAH_RESET);
            thr_reg     <= AVG_WIDTH'(THR_RESET);
        end
        else
        begin
            phase_reg   <= phase_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            dit_reg     <= dit_next;
            dah_reg     <= dah_next;
            thr_reg     <= thr_next;
        end
    end

    assign dit_avg = dit_next;
    assign dah_avg = dah_next;
    assign thr_avg = thr_next;

    `AMKC_ASSERT_IMP(a_dit_floor, clk, rst_n, sym == SYM_DIT, dit_next >= floor_eff)
    `AMKC_ASSERT_IMP(a_dah_cap, clk, rst_n, sym == SYM_DAH, dah_next <= cap)
    `AMKC_ASSERT_IMP(a_mark_on_release, clk, rst_n, sym == SYM_DIT || sym == SYM_DAH,
                     phase_reg == PH_DOWN && !key)
    `AMKC_ASSERT_NEXT(a_press_enters_down, clk, rst_n, step && key, phase_reg == PH_DOWN)
    `AMKC_ASSERT_NEXT(a_hold_without_step, clk, rst_n, !step,
                      $stable(dit_reg) && $stable(dah_reg) && $stable(thr_reg))

endmodule

### hw/rtl/adaptive_morse_key_classifier_core.sv
// ----------------------------------------------------------------------------
// Adaptive Morse key classifier
// Turns timestamped key samples into dits, dahs and character and word
// breaks, tracking the operator's speed with running averages.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat
//  sample    in         key_pressed, now_ms
//  result    out        symbol, dit_average, dah_average, split_threshold
//  wr_*      in         register write, index 0 to 3, no read-back
//
// A sample is taken every cycle unless the sink stalls; it goes to the input and
// output registers. The rate is set by the combinational state update: timestamp
// difference, nine-to-one average through a reciprocal multiply by ten, compares.
// Reset loads the default averages and limits at once; there is no clearing pass.
// A result held by the sink stalls a full input register and drops sample.ready.
module adaptive_morse_key_classifier_core #(
    parameter int TIME_WIDTH = amkc_pkg::TIME_WIDTH_DEF,
    parameter int AVG_WIDTH  = amkc_pkg::AVG_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [amkc_pkg::REG_IDX_W-1:0] wr_index,
    input  logic [amkc_pkg::FIELD_W-1:0]   wr_data,
    amkc_sample_if.sink                    sample,
    amkc_result_if.source                  result
);
    import amkc_pkg::*;

    cfg_t cfg;

    logic               in_vld_reg;
    logic               in_vld_next;
    logic               key_reg;
    logic [NOW_W-1:0]   now_reg;
    logic               out_vld_reg;
    logic               out_vld_next;
    logic [SYM_W-1:0]   sym_reg;
    logic [FIELD_W-1:0] dit_reg;
    logic [FIELD_W-1:0] dah_reg;
    logic [FIELD_W-1:0] thr_reg;

    logic                 advance;
    logic                 step;
    logic                 accept;
    logic [SYM_W-1:0]     sym;
    logic [AVG_WIDTH-1:0] dit_avg;
    logic [AVG_WIDTH-1:0] dah_avg;
    logic [AVG_WIDTH-1:0] thr_avg;

    amkc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    amkc_engine #(
        .TIME_WIDTH (TIME_WIDTH),
        .AVG_WIDTH  (AVG_WIDTH)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .key     (key_reg),
        .now     (now_reg),
        .cfg     (cfg),
        .sym     (sym),
        .dit_avg (dit_avg),
        .dah_avg (dah_avg),
        .thr_avg (thr_avg)
    );

    assign advance      = !out_vld_reg || result.ready;
    assign step         = in_vld_reg && advance;
    assign sample.ready = !in_vld_reg || advance;
    assign accept       = sample.valid && sample.ready;

    assign in_vld_next  = accept || (in_vld_reg && !advance);
    assign out_vld_next = advance ? in_vld_reg : out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg <= sample.key_pressed;
            now_reg <= sample.now_ms;
        end
        if (step)
        begin
            sym_reg <= sym;
            dit_reg <= FIELD_W'(dit_avg);
            dah_reg <= FIELD_W'(dah_avg);
            thr_reg <= FIELD_W'(thr_avg);
        end
    end

    assign result.valid           = out_vld_reg;
    assign result.symbol          = sym_reg;
    assign result.dit_average     = dit_reg;
    assign result.dah_average     = dah_reg;
    assign result.split_threshold = thr_reg;

endmodule
